FILE: hw/rtl/jas_pkg.sv
// Shared constants and helpers for the JPEG Adobe APP14 scanner.
package jas_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_SOI0    = 3'd0;
    localparam logic [2:0] PH_SOI1    = 3'd1;
    localparam logic [2:0] PH_MARKER  = 3'd2;
    localparam logic [2:0] PH_LENHI   = 3'd3;
    localparam logic [2:0] PH_LENLO   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // Marker and length constants
    localparam logic [7:0]  BYTE_FILL   = 8'hFF;
    localparam logic [7:0]  MARK_SOI    = 8'hD8;
    localparam logic [7:0]  MARK_SOS    = 8'hDA;
    localparam logic [7:0]  MARK_EOI    = 8'hD9;
    localparam logic [7:0]  MARK_TEM0   = 8'h00;
    localparam logic [7:0]  MARK_TEM1   = 8'h01;
    localparam logic [7:0]  MARK_RST_LO = 8'hD0;
    localparam logic [7:0]  MARK_RST_HI = 8'hD7;
    localparam logic [7:0]  MARK_APP14  = 8'hEE;
    localparam logic [15:0] LEN_MIN     = 16'd2;
    localparam logic [15:0] LEN_ADOBE   = 16'd14;
    localparam logic [2:0]  TAG_LEN     = 3'd5;

    // Bytes of the identifier "Adobe"
    function automatic logic [7:0] adobe_tag(input logic [2:0] idx);
        logic [7:0] res;
        case (idx)
            3'd0:    res = 8'h41;
            3'd1:    res = 8'h64;
            3'd2:    res = 8'h6F;
            3'd3:    res = 8'h62;
            3'd4:    res = 8'h65;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/jas_byte_if.sv
// Byte stream channel: one file byte and its last-byte flag per transaction.
interface jas_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

FILE: hw/rtl/jas_result_if.sv
// Result channel: one found flag per file.
interface jas_result_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

FILE: hw/rtl/jpeg_adobe_app14_scanner.sv
// Top level: scans a JPEG byte stream for an Adobe APP14 segment before SOS/EOI.
//
// Usage:
//   stream carries one byte of the encoded file per transaction, with
//   end_of_file set on the last byte of each file. result carries exactly
//   one found flag per file, issued on the byte that settles the answer
//   (an Adobe segment completing, SOS/EOI, a bad header or length, or the
//   last byte of the file). Bytes after the decision are consumed silently
//   up to end_of_file, after which the parser restarts for the next file.
//   Throughput: one byte per cycle while stream.ready is high, set by the
//   parser state update. The result is registered: it enters the output
//   register as the deciding byte is accepted.
//   Stall: the output register holds one result; while it is full and
//   result.ready is low, stream.ready drops. While it is being drained,
//   a new byte is still taken in the same cycle.
//   Reset: rst_n (asynchronous, active low) clears the parser to expect the
//   first SOI byte and empties the output register.
module jpeg_adobe_app14_scanner (
    input  logic                clk,
    input  logic                rst_n,
    jas_byte_if.sink            stream,
    jas_result_if.source        result
);

    logic [2:0]  phase_reg,        phase_next;
    logic [15:0] segment_left_reg, segment_left_next;
    logic [7:0]  length_high_reg,  length_high_next;
    logic [2:0]  match_index_reg,  match_index_next;
    logic        candidate_reg,    candidate_next;
    logic        decided_reg,      decided_next;
    logic        out_valid_reg;
    logic        found_reg;

    logic        accept;
    logic        emit;
    logic        value;
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] left_dec;

    assign b        = stream.data_byte;
    assign len      = {length_high_reg, b};
    assign left_dec = segment_left_reg - 16'd1;

    // Take a byte whenever the output register is empty or draining
    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    // Compute next parser state for the presented byte
    always_comb
    begin
        phase_next        = phase_reg;
        segment_left_next = segment_left_reg;
        length_high_next  = length_high_reg;
        match_index_next  = match_index_reg;
        candidate_next    = candidate_reg;
        decided_next      = decided_reg;
        emit              = 1'b0;
        value             = 1'b0;

        if (!decided_reg)
        begin
            case (phase_reg)
                jas_pkg::PH_SOI0:
                begin
                    if (b == jas_pkg::BYTE_FILL)
                        phase_next = jas_pkg::PH_SOI1;
                    else
                        emit = 1'b1;
                end
                jas_pkg::PH_SOI1:
                begin
                    if (b == jas_pkg::MARK_SOI)
                        phase_next = jas_pkg::PH_MARKER;
                    else
                        emit = 1'b1;
                end
                jas_pkg::PH_LENHI:
                begin
                    length_high_next = b;
                    phase_next       = jas_pkg::PH_LENLO;
                end
                jas_pkg::PH_LENLO:
                begin
                    if (len < jas_pkg::LEN_MIN)
                        emit = 1'b1;
                    else
                    begin
                        candidate_next    = candidate_reg && (len >= jas_pkg::LEN_ADOBE);
                        segment_left_next = len - jas_pkg::LEN_MIN;
                        match_index_next  = 3'd0;
                        phase_next        = (len == jas_pkg::LEN_MIN) ?
                                            jas_pkg::PH_MARKER : jas_pkg::PH_PAYLOAD;
                    end
                end
                jas_pkg::PH_PAYLOAD:
                begin
                    // compare the leading payload bytes against the tag
                    if (match_index_reg < jas_pkg::TAG_LEN)
                    begin
                        if (b != jas_pkg::adobe_tag(match_index_reg))
                            candidate_next = 1'b0;
                        match_index_next = match_index_reg + 3'd1;
                    end
                    segment_left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        if (candidate_next)
                        begin
                            emit  = 1'b1;
                            value = 1'b1;
                        end
                        else
                            phase_next = jas_pkg::PH_MARKER;
                    end
                end
                default:
                begin
                    // marker search: skip fill and stand-alone markers
                    if (b == jas_pkg::BYTE_FILL)
                    begin
                        phase_next = phase_reg;
                    end
                    else if (b == jas_pkg::MARK_SOS || b == jas_pkg::MARK_EOI)
                        emit = 1'b1;
                    else if (b == jas_pkg::MARK_TEM0 || b == jas_pkg::MARK_TEM1 ||
                             (b >= jas_pkg::MARK_RST_LO && b <= jas_pkg::MARK_RST_HI))
                    begin
                        phase_next = phase_reg;
                    end
                    else
                    begin
                        candidate_next = (b == jas_pkg::MARK_APP14);
                        phase_next     = jas_pkg::PH_LENHI;
                    end
                end
            endcase

            // end of file forces a negative answer if still open
            if (!emit && stream.end_of_file)
            begin
                emit  = 1'b1;
                value = 1'b0;
            end
            if (emit)
                decided_next = 1'b1;
        end

        // restart for the next file
        if (stream.end_of_file)
        begin
            phase_next        = jas_pkg::PH_SOI0;
            segment_left_next = 16'd0;
            length_high_next  = 8'd0;
            match_index_next  = 3'd0;
            candidate_next    = 1'b0;
            decided_next      = 1'b0;
        end
    end

    // Advance parser state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= jas_pkg::PH_SOI0;
            segment_left_reg <= 16'd0;
            length_high_reg  <= 8'd0;
            match_index_reg  <= 3'd0;
            candidate_reg    <= 1'b0;
            decided_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            segment_left_reg <= segment_left_next;
            length_high_reg  <= length_high_next;
            match_index_reg  <= match_index_next;
            candidate_reg    <= candidate_next;
            decided_reg      <= decided_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            found_reg <= value;
    end

    assign result.valid = out_valid_reg;
    assign result.found = found_reg;

endmodule
